>>> design/gde_pkg.sv
`timescale 1ns / 1ps

package gde_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int COUNT_W_MAX    = 16;

    localparam logic [13:0] LAST_YEAR   = 14'd9999;
    localparam logic [13:0] YEARS_400   = 14'd400;
    localparam logic [13:0] YEARS_100   = 14'd100;
    localparam logic [8:0]  Y400_LAST   = 9'd399;
    localparam logic [6:0]  Y100_LAST   = 7'd99;
    localparam logic [2:0]  WD_YEAR_ZERO = 3'd6;   // 1.1.0000 was a saturday

    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_COUNT   = 2'd1,
        OP_WEEKDAY = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // year first so a packed compare orders dates
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    localparam date_t LAST_DATE = '{year: 14'd9999, month: 4'd12, day: 5'd31};

    typedef struct packed {
        logic       load;
        logic       step;
        date_t      date;
        logic [8:0] y400;
        logic [6:0] y100;
    } walk_ctrl_t;

    typedef struct packed {
        date_t      date;
        logic       leap;
        logic [8:0] y400;
    } walk_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD400,
        ST_MOD100,
        ST_CHECK_START,
        ST_CHECK_END,
        ST_WALK,
        ST_WEEK_YEARS,
        ST_WEEK_MONTH,
        ST_WEEK_DAY,
        ST_DONE
    } state_t;

    function automatic logic leap_of(input logic [8:0] y400, input logic [6:0] y100);
        return ((y400[1:0] == 2'd0) && (y100 != 7'd0)) || (y400 == 9'd0);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the month, modulo 7
    function automatic logic [2:0] dbm_mod7(input logic [3:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd6;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd6;
            4'd8:    r = 3'd2;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd0;
            4'd11:   r = 3'd3;
            4'd12:   r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [3:0] b);
        logic [3:0] s;
        s = {1'b0, a} + b;
        if (s >= 4'd7)
            s = s - 4'd7;
        return s[2:0];
    endfunction

    function automatic logic [2:0] mod7_small(input logic [4:0] x);
        logic [4:0] r;
        r = x;
        for (int i = 0; i < 4; i++)
        begin
            if (r >= 5'd7)
                r = r - 5'd7;
        end
        return r[2:0];
    endfunction

endpackage

>>> design/gregorian_date_engine_top.sv
`timescale 1ns / 1ps

// channel   handshake            fields
// --------  -------------------  -------------------------------------------------
// command   start / busy         op, start_day, start_month, start_year, day_steps,
//                                end_day, end_month, end_year
// result    done (one cycle)     start_valid, end_valid, overflow, result_day,
//                                result_month, result_year, weekday, day_count
//
// a command transfers when start is high and busy is low; busy stays high until done
// year reduction modulo 400 and 100 by repeated subtraction in one shared remainder register
// advance steps one day at a time, up to 2^CNT_W - 1 days (the 16-bit step field saturates),
// count one day at a time across the span, weekday one year at a time over the 400-year cycle,
// each after the date range checks
// asynchronous reset returns the sequencer to idle; the receiver cannot stall done

module gregorian_date_engine_top #(
    parameter int COUNT_BITS = gde_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [6:0]  start_day,
    input  logic [6:0]  start_month,
    input  logic [13:0] start_year,
    input  logic [15:0] day_steps,
    input  logic [6:0]  end_day,
    input  logic [6:0]  end_month,
    input  logic [13:0] end_year,
    output logic        done,
    output logic        start_valid,
    output logic        end_valid,
    output logic        overflow,
    output logic [4:0]  result_day,
    output logic [3:0]  result_month,
    output logic [13:0] result_year,
    output logic [2:0]  weekday,
    output logic [15:0] day_count
);

    localparam int CNT_W = (COUNT_BITS < gde_pkg::COUNT_W_MAX) ? COUNT_BITS
                                                               : gde_pkg::COUNT_W_MAX;
    localparam logic [CNT_W-1:0] LIMIT   = {CNT_W{1'b1}};
    localparam logic [15:0]      LIMIT16 = 16'((32'd1 << CNT_W) - 32'd1);

    gde_pkg::state_t state_reg, state_next;

    gde_pkg::op_t   op_reg, op_next;
    logic [6:0]     sd_reg, sd_next, sm_reg, sm_next, ed_reg, ed_next, em_reg, em_next;
    logic [13:0]    sy_reg, sy_next, ey_reg, ey_next;
    logic [15:0]    steps_reg, steps_next;
    logic [13:0]    rem_reg, rem_next;
    logic [8:0]     tmp400_reg, tmp400_next;
    logic           side_reg, side_next;
    logic           end_leap_reg, end_leap_next;
    logic           sv_reg, sv_next, ev_reg, ev_next, ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]     wd_reg, wd_next;
    logic [8:0]     k_reg, k_next;
    logic [6:0]     k100_reg, k100_next;

    gde_pkg::walk_ctrl_t   walk_ctrl;
    gde_pkg::walk_status_t walk_status;

    logic           accept;
    logic           rem_ge400, rem_ge100;
    logic           sv_cond, ev_cond, end_before, at_last, at_end, cnt_zero, cnt_full, k_done;
    logic [15:0]    steps_sat;
    gde_pkg::date_t end_date;
    logic [3:0]     month_add;

    gde_walker u_walker (
        .clk    (clk),
        .ctrl   (walk_ctrl),
        .status (walk_status)
    );

    assign accept    = (state_reg == gde_pkg::ST_IDLE) && start;
    assign rem_ge400 = rem_reg >= gde_pkg::YEARS_400;
    assign rem_ge100 = rem_reg >= gde_pkg::YEARS_100;

    assign sv_cond = (sy_reg <= gde_pkg::LAST_YEAR) && (sm_reg >= 7'd1) && (sm_reg <= 7'd12)
                     && (sd_reg >= 7'd1)
                     && (sd_reg <= {2'b00, gde_pkg::month_len(sm_reg[3:0], walk_status.leap)});
    assign ev_cond = (ey_reg <= gde_pkg::LAST_YEAR) && (em_reg >= 7'd1) && (em_reg <= 7'd12)
                     && (ed_reg >= 7'd1)
                     && (ed_reg <= {2'b00, gde_pkg::month_len(em_reg[3:0], end_leap_reg)});

    assign end_date   = '{year: ey_reg, month: em_reg[3:0], day: ed_reg[4:0]};
    assign end_before = end_date < walk_status.date;
    assign at_end     = walk_status.date == end_date;
    assign at_last    = walk_status.date == gde_pkg::LAST_DATE;
    assign cnt_zero   = cnt_reg == '0;
    assign cnt_full   = cnt_reg == LIMIT;
    assign k_done     = k_reg == walk_status.y400;
    assign steps_sat  = (steps_reg > LIMIT16) ? LIMIT16 : steps_reg;
    assign month_add  = {1'b0, gde_pkg::dbm_mod7(walk_status.date.month)}
                        + {3'b000, (walk_status.date.month > 4'd2) && walk_status.leap};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gde_pkg::ST_IDLE:
                if (start)
                    state_next = gde_pkg::ST_MOD400;
            gde_pkg::ST_MOD400:
                if (!rem_ge400)
                    state_next = gde_pkg::ST_MOD100;
            gde_pkg::ST_MOD100:
                if (!rem_ge100)
                    state_next = side_reg ? gde_pkg::ST_CHECK_END : gde_pkg::ST_CHECK_START;
            gde_pkg::ST_CHECK_START:
                if (!sv_cond)
                    state_next = gde_pkg::ST_DONE;
                else
                begin
                    unique case (op_reg)
                        gde_pkg::OP_ADVANCE: state_next = gde_pkg::ST_WALK;
                        gde_pkg::OP_COUNT:   state_next = gde_pkg::ST_MOD400;
                        gde_pkg::OP_WEEKDAY: state_next = gde_pkg::ST_WEEK_YEARS;
                        default:             state_next = gde_pkg::ST_DONE;
                    endcase
                end
            gde_pkg::ST_CHECK_END:
                if (!ev_cond || end_before)
                    state_next = gde_pkg::ST_DONE;
                else
                    state_next = gde_pkg::ST_WALK;
            gde_pkg::ST_WALK:
                if (op_reg == gde_pkg::OP_ADVANCE)
                begin
                    if (cnt_zero || at_last)
                        state_next = gde_pkg::ST_DONE;
                end
                else if (at_end || cnt_full)
                    state_next = gde_pkg::ST_DONE;
            gde_pkg::ST_WEEK_YEARS:
                if (k_done)
                    state_next = gde_pkg::ST_WEEK_MONTH;
            gde_pkg::ST_WEEK_MONTH:
                state_next = gde_pkg::ST_WEEK_DAY;
            gde_pkg::ST_WEEK_DAY:
                state_next = gde_pkg::ST_DONE;
            gde_pkg::ST_DONE:
                state_next = gde_pkg::ST_IDLE;
            default:
                state_next = gde_pkg::ST_IDLE;
        endcase
    end

    // datapath and walker control
    always_comb
    begin
        op_next       = op_reg;
        sd_next       = sd_reg;
        sm_next       = sm_reg;
        sy_next       = sy_reg;
        ed_next       = ed_reg;
        em_next       = em_reg;
        ey_next       = ey_reg;
        steps_next    = steps_reg;
        rem_next      = rem_reg;
        tmp400_next   = tmp400_reg;
        side_next     = side_reg;
        end_leap_next = end_leap_reg;
        sv_next       = sv_reg;
        ev_next       = ev_reg;
        ovf_next      = ovf_reg;
        cnt_next      = cnt_reg;
        wd_next       = wd_reg;
        k_next        = k_reg;
        k100_next     = k100_reg;
        walk_ctrl      = '0;
        walk_ctrl.date = '{year: sy_reg, month: sm_reg[3:0], day: sd_reg[4:0]};
        walk_ctrl.y400 = tmp400_reg;
        walk_ctrl.y100 = rem_reg[6:0];

        unique case (state_reg)
            gde_pkg::ST_IDLE:
                if (accept)
                begin
                    op_next    = gde_pkg::op_t'(op);
                    sd_next    = start_day;
                    sm_next    = start_month;
                    sy_next    = start_year;
                    ed_next    = end_day;
                    em_next    = end_month;
                    ey_next    = end_year;
                    steps_next = day_steps;
                    rem_next   = start_year;
                    side_next  = 1'b0;
                    sv_next    = 1'b0;
                    ev_next    = 1'b0;
                    ovf_next   = 1'b0;
                    cnt_next   = '0;
                end
            gde_pkg::ST_MOD400:
                if (rem_ge400)
                    rem_next = rem_reg - gde_pkg::YEARS_400;
                else
                    tmp400_next = rem_reg[8:0];
            gde_pkg::ST_MOD100:
                if (rem_ge100)
                    rem_next = rem_reg - gde_pkg::YEARS_100;
                else if (side_reg)
                    end_leap_next = gde_pkg::leap_of(tmp400_reg, rem_reg[6:0]);
                else
                    walk_ctrl.load = 1'b1;
            gde_pkg::ST_CHECK_START:
            begin
                sv_next = sv_cond;
                if (sv_cond)
                begin
                    unique case (op_reg)
                        gde_pkg::OP_ADVANCE:
                            cnt_next = CNT_W'(steps_sat);
                        gde_pkg::OP_COUNT:
                        begin
                            rem_next  = ey_reg;
                            side_next = 1'b1;
                        end
                        gde_pkg::OP_WEEKDAY:
                        begin
                            wd_next   = gde_pkg::WD_YEAR_ZERO;
                            k_next    = '0;
                            k100_next = '0;
                        end
                        default:
                            cnt_next = '0;
                    endcase
                end
            end
            gde_pkg::ST_CHECK_END:
            begin
                ev_next = ev_cond;
                if (ev_cond && end_before)
                begin
                    ovf_next = 1'b1;
                    cnt_next = LIMIT;
                end
                else
                    cnt_next = '0;
            end
            gde_pkg::ST_WALK:
                if (op_reg == gde_pkg::OP_ADVANCE)
                begin
                    if (!cnt_zero)
                    begin
                        if (at_last)
                            ovf_next = 1'b1;
                        else
                        begin
                            walk_ctrl.step = 1'b1;
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                    end
                end
                else if (!at_end)
                begin
                    if (cnt_full)
                        ovf_next = 1'b1;
                    else
                    begin
                        walk_ctrl.step = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            gde_pkg::ST_WEEK_YEARS:
                if (!k_done)
                begin
                    // leap years move the weekday by two
                    wd_next   = gde_pkg::add_mod7(wd_reg,
                                    gde_pkg::leap_of(k_reg, k100_reg) ? 4'd2 : 4'd1);
                    k_next    = k_reg + 9'd1;
                    k100_next = (k100_reg == gde_pkg::Y100_LAST) ? 7'd0 : k100_reg + 7'd1;
                end
            gde_pkg::ST_WEEK_MONTH:
                wd_next = gde_pkg::add_mod7(wd_reg, month_add);
            gde_pkg::ST_WEEK_DAY:
                wd_next = gde_pkg::add_mod7(wd_reg,
                              {1'b0, gde_pkg::mod7_small(walk_status.date.day - 5'd1)});
            gde_pkg::ST_DONE:
                cnt_next = cnt_reg;
            default:
                cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gde_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        sd_reg       <= sd_next;
        sm_reg       <= sm_next;
        sy_reg       <= sy_next;
        ed_reg       <= ed_next;
        em_reg       <= em_next;
        ey_reg       <= ey_next;
        steps_reg    <= steps_next;
        rem_reg      <= rem_next;
        tmp400_reg   <= tmp400_next;
        side_reg     <= side_next;
        end_leap_reg <= end_leap_next;
        sv_reg       <= sv_next;
        ev_reg       <= ev_next;
        ovf_reg      <= ovf_next;
        cnt_reg      <= cnt_next;
        wd_reg       <= wd_next;
        k_reg        <= k_next;
        k100_reg     <= k100_next;
    end

    assign busy = state_reg != gde_pkg::ST_IDLE;
    assign done = state_reg == gde_pkg::ST_DONE;

    assign start_valid  = sv_reg;
    assign end_valid    = ev_reg;
    assign overflow     = ovf_reg;
    assign result_day   = (sv_reg && op_reg == gde_pkg::OP_ADVANCE) ? walk_status.date.day   : '0;
    assign result_month = (sv_reg && op_reg == gde_pkg::OP_ADVANCE) ? walk_status.date.month : '0;
    assign result_year  = (sv_reg && op_reg == gde_pkg::OP_ADVANCE) ? walk_status.date.year  : '0;
    assign weekday      = (sv_reg && op_reg == gde_pkg::OP_WEEKDAY) ? wd_reg : '0;
    assign day_count    = (ev_reg && op_reg == gde_pkg::OP_COUNT) ? 16'(cnt_reg) : '0;

endmodule

>>> design/gde_walker.sv
`timescale 1ns / 1ps

module gde_walker (
    input  logic                  clk,
    input  gde_pkg::walk_ctrl_t   ctrl,
    output gde_pkg::walk_status_t status
);

    gde_pkg::date_t date_reg, date_next;
    logic [8:0]     y400_reg, y400_next;
    logic [6:0]     y100_reg, y100_next;
    logic           leap;
    logic [4:0]     len;

    assign leap = gde_pkg::leap_of(y400_reg, y100_reg);
    assign len  = gde_pkg::month_len(date_reg.month, leap);

    always_comb
    begin
        date_next = date_reg;
        y400_next = y400_reg;
        y100_next = y100_reg;
        if (ctrl.load)
        begin
            date_next = ctrl.date;
            y400_next = ctrl.y400;
            y100_next = ctrl.y100;
        end
        else if (ctrl.step)
        begin
            if (date_reg.day < len)
                date_next.day = date_reg.day + 5'd1;
            else
            begin
                date_next.day = 5'd1;
                if (date_reg.month == 4'd12)
                begin
                    date_next.month = 4'd1;
                    date_next.year  = date_reg.year + 14'd1;
                    y400_next = (y400_reg == gde_pkg::Y400_LAST) ? 9'd0 : y400_reg + 9'd1;
                    y100_next = (y100_reg == gde_pkg::Y100_LAST) ? 7'd0 : y100_reg + 7'd1;
                end
                else
                    date_next.month = date_reg.month + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        date_reg <= date_next;
        y400_reg <= y400_next;
        y100_reg <= y100_next;
    end

    assign status.date = date_reg;
    assign status.leap = leap;
    assign status.y400 = y400_reg;

endmodule
